/* rtl/rcm_pkg.sv */
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types and constants for the rod cutting revenue block: sizes,
// transaction structs, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package rcm_pkg;

	// Longest rod handled; longer lists drop the surplus prices
	localparam int MAX_LEN   = 64;
	localparam int PRICE_W   = 16;
	localparam int REV_W     = 22;
	localparam int LEN_W     = 7;
	// Counters and revenue table index: hold 0..MAX_LEN
	localparam int CNT_W     = $clog2(MAX_LEN + 1);
	localparam int REV_DEPTH = MAX_LEN + 1;
	// Price store index: 0..MAX_LEN-1
	localparam int PADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	localparam logic [REV_W-1:0] REV_MAX = '1;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [REV_W-1:0] best_revenue;
		logic [LEN_W-1:0] rod_length;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_RUN,
		ST_DRAIN,
		ST_WRITE,
		ST_DONE
	} rcm_state_t;

	// Controller to datapath
	typedef struct packed {
		logic store;      // store the incoming price
		logic finish;     // incoming price ends the list
		logic init;       // write r[0] = 0, start at j = 1
		logic issue;      // read price[i-1] and r[j-i]
		logic write_rev;  // write r[j], move to next j
		logic load_out;   // move r[n] and n into the output register
	} rcm_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic i_last;     // i has reached j
		logic j_last;     // j has reached n
		logic out_free;   // output register can take a result this cycle
	} rcm_status_t;

endpackage

/* rtl/rcm_ctrl.sv */
// ----------------------------------------------------------------------------
// rcm_ctrl
// Controller: sequences price loading, the bottom-up table fill and the
// hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module rcm_ctrl
	import rcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_last,
	output logic        in_stall,
	input  rcm_status_t status,
	output rcm_cmd_t    cmd
);

	rcm_state_t state_q;
	rcm_state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid && in_last) begin
					state_next = ST_INIT;
				end
			end
			ST_INIT: begin
				state_next = ST_RUN;
			end
			ST_RUN: begin
				if (status.i_last) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_next = ST_WRITE;
			end
			ST_WRITE: begin
				if (status.j_last) begin
					state_next = ST_DONE;
				end else begin
					state_next = ST_RUN;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					state_next = ST_LOAD;
				end
			end
			default: begin
				state_next = ST_LOAD;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_LOAD: begin
				in_stall   = 1'b0;
				cmd.store  = in_valid;
				cmd.finish = in_valid && in_last;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
				cmd = '0;
			end
			ST_WRITE: begin
				cmd.write_rev = 1'b1;
			end
			ST_DONE: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/rcm_dp.sv */
// ----------------------------------------------------------------------------
// rcm_dp
// Datapath: price store, revenue table, loop counters, the add/compare
// accumulator and the output register.
// ----------------------------------------------------------------------------
module rcm_dp
	import rcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    in_item,
	input  rcm_cmd_t    cmd,
	output rcm_status_t status,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item
);

	logic [PRICE_W-1:0] price_mem_q [MAX_LEN];
	logic [REV_W-1:0]   rev_mem_q   [REV_DEPTH];

	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   j_q;
	logic               rd_valid_s1;
	logic               first_s1;
	logic [PRICE_W-1:0] price_rd_s1;
	logic [REV_W-1:0]   rev_rd_s1;
	logic [REV_W-1:0]   best_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [CNT_W-1:0]   cnt_inc;
	logic               cnt_room;
	logic [CNT_W-1:0]   i_minus1;
	logic [CNT_W-1:0]   rev_raddr;
	logic [REV_W:0]     cand;
	logic [REV_W-1:0]   cand_sat;
	logic [CNT_W-1:0]   rev_waddr;
	logic [REV_W-1:0]   rev_wdata;

	// Load count saturates at the store depth
	assign cnt_room = cnt_q < CNT_W'(MAX_LEN);
	assign cnt_inc  = cnt_room ? cnt_q + 1'b1 : cnt_q;

	// Read addresses: price[i-1] and r[j-i]
	assign i_minus1  = i_q - 1'b1;
	assign rev_raddr = j_q - i_q;

	// Candidate price + revenue, clamped to the field width
	assign cand     = {1'b0, rev_rd_s1} + (REV_W + 1)'(price_rd_s1);
	assign cand_sat = cand[REV_W] ? REV_MAX : cand[REV_W-1:0];

	// Table write: r[0] on init, r[j] at the end of each row
	assign rev_waddr = cmd.init ? '0 : j_q;
	assign rev_wdata = cmd.init ? '0 : best_q;

	// Price store
	always_ff @(posedge clk) begin
		if (cmd.store && cnt_room) begin
			price_mem_q[cnt_q[PADDR_W-1:0]] <= in_item.price;
		end
		if (cmd.issue) begin
			price_rd_s1 <= price_mem_q[i_minus1[PADDR_W-1:0]];
		end
	end

	// Revenue table
	always_ff @(posedge clk) begin
		if (cmd.init || cmd.write_rev) begin
			rev_mem_q[rev_waddr] <= rev_wdata;
		end
		if (cmd.issue) begin
			rev_rd_s1 <= rev_mem_q[rev_raddr];
		end
	end

	// Counters and read pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			rd_valid_s1 <= 1'b0;
			first_s1    <= 1'b0;
		end else begin
			if (cmd.store) begin
				cnt_q <= cmd.finish ? '0 : cnt_inc;
			end
			if (cmd.finish) begin
				n_q <= cnt_inc;
			end
			rd_valid_s1 <= cmd.issue;
			if (cmd.issue) begin
				first_s1 <= (i_q == CNT_W'(1));
				i_q      <= i_q + 1'b1;
			end
			if (cmd.init) begin
				i_q <= CNT_W'(1);
				j_q <= CNT_W'(1);
			end
			if (cmd.write_rev) begin
				i_q <= CNT_W'(1);
				j_q <= j_q + 1'b1;
			end
		end
	end

	// Running maximum over the row
	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			if (first_s1 || cand_sat > best_q) begin
				best_q <= cand_sat;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.best_revenue <= best_q;
			out_q.rod_length   <= LEN_W'(n_q);
		end
	end

	assign status.i_last   = (i_q == j_q);
	assign status.j_last   = (j_q == n_q);
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* rtl/rod_cutting_max_revenue.sv */
// ----------------------------------------------------------------------------
// rod_cutting_max_revenue
// Maximum revenue from cutting a rod, filled bottom-up from a price list.
// ----------------------------------------------------------------------------
// Prices arrive one transaction per cycle while the input is not stalled,
// the k-th being the price of a piece of length k; the transaction flagged
// last ends the list and its count n is the rod length (prices beyond
// MAX_LEN are dropped, n stops at MAX_LEN). The block then stalls its input
// while it fills the revenue table with a single adder/comparator, one
// candidate price[i]+r[j-i] per cycle; each row ends with a drain of the
// read pipeline into the accumulator and the write of r[j]. When the output
// register is free, r[n] and n move into it and loading resumes, so the
// next list can load while the result waits to be taken.
module rod_cutting_max_revenue
	import rcm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	rcm_cmd_t    cmd;
	rcm_status_t status;

	// Sequencer
	rcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_item.last),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Stores, accumulator and output register
	rcm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

/* rtl/rcm_checker.sv */
// ----------------------------------------------------------------------------
// rcm_checker
// Port-level checks on the rod cutting block, bound to the top level.
// ----------------------------------------------------------------------------
module rcm_checker
	import rcm_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// The end of a list stops loading while the table fills
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.last |=> in_stall)
		else $error("input not stalled after last price");

	// A new result only appears at the end of a fill
	a_out_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a table fill");

endmodule

bind rod_cutting_max_revenue rcm_checker u_rcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

/* tb/rod_cutting_max_revenue_test.sv */
// ----------------------------------------------------------------------------
// rod_cutting_max_revenue_test
// Self-checking bench for the rod cutting revenue block: price lists are fed
// in, each closing transaction is predicted with a bottom-up revenue table
// and the block's results are checked in order against those predictions.
// ----------------------------------------------------------------------------
module rod_cutting_max_revenue_test
	import rcm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1650;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 50;
	localparam int HOLD_AT      = 40;
	localparam int HOLD_CYCLES  = 600;

	typedef enum int {
		PAT_RANDOM,
		PAT_PEAK,
		PAT_ZERO,
		PAT_LOW,
		PAT_RISING
	} price_pattern_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;

	in_item_t           price_feed[$];     // transactions still to send
	logic [PRICE_W-1:0] loading_prices[$]; // prices of the list being loaded
	out_item_t          revenue_due[$];    // predicted results, oldest first

	int unsigned send_gap;
	int unsigned items_sent;
	int unsigned take_wait;
	int unsigned results_taken;
	int unsigned hold_left;
	logic        hold_done;
	int unsigned cycle_count = 0;
	int unsigned errors = 0;

	rod_cutting_max_revenue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		errors++;
	endtask

	// Best revenue for the whole rod over the prices loaded so far
	function automatic out_item_t best_cut_revenue();
		longint unsigned rev [0:MAX_LEN];
		longint unsigned best;
		longint unsigned cand;
		int              n;
		out_item_t       res;
		n = loading_prices.size();
		rev[0] = 0;
		for (int j = 1; j <= n; j++) begin
			best = 0;
			for (int i = 1; i <= j; i++) begin
				cand = loading_prices[i-1] + rev[j-i];
				if (cand > best)
					best = cand;
			end
			if (best > REV_MAX)
				best = REV_MAX;
			rev[j] = best;
		end
		res.best_revenue = rev[n][REV_W-1:0];
		res.rod_length   = n[LEN_W-1:0];
		return res;
	endfunction

	// Track one accepted price; a closing transaction yields one result
	task automatic take_price(input in_item_t item);
		if (loading_prices.size() < MAX_LEN)
			loading_prices.push_back(item.price);
		if (item.last) begin
			revenue_due.push_back(best_cut_revenue());
			loading_prices.delete();
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (revenue_due.size() == 0) begin
			flag_mismatch($sformatf("result %0d/%0d with nothing expected",
				got.best_revenue, got.rod_length));
		end else begin
			want = revenue_due.pop_front();
			if (got.best_revenue !== want.best_revenue)
				flag_mismatch($sformatf("best_revenue %0d, expected %0d (n=%0d)",
					got.best_revenue, want.best_revenue, want.rod_length));
			if (got.rod_length !== want.rod_length)
				flag_mismatch($sformatf("rod_length %0d, expected %0d",
					got.rod_length, want.rod_length));
		end
	endtask

	task automatic add_price(input int price, input bit last);
		in_item_t item;
		item.price = price[PRICE_W-1:0];
		item.last  = last;
		price_feed.push_back(item);
	endtask

	task automatic add_list(input int len, input price_pattern_t pat);
		int price;
		for (int k = 1; k <= len; k++) begin
			case (pat)
				PAT_PEAK:   price = 65535;
				PAT_ZERO:   price = 0;
				PAT_LOW:    price = $urandom_range(0, 15);
				PAT_RISING: price = k * 997 + $urandom_range(0, 300);
				default:    price = $urandom_range(0, 65535);
			endcase
			add_price(price, k == len);
		end
	endtask

	// Driver: offers queued transactions, with a random gap after each outside the back-to-back stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_item    <= '0;
			send_gap   <= 0;
			items_sent <= 0;
		end else begin
			if (in_valid && !in_stall)
				take_price(in_item);
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (price_feed.size() != 0) begin
					in_item    <= price_feed.pop_front();
					in_valid   <= 1'b1;
					items_sent <= items_sent + 1;
					// every third stretch of 40 goes back to back
					send_gap   <= ((items_sent / 40) % 3 == 0) ? 0 : $urandom_range(0, 11);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, once, so the block fills and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_taken >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Monitor: checks each result, then stalls at random outside every third stretch of 8 results and during the hold-off
	always @(posedge clk or negedge arst_n) begin : monitor
		int unsigned next_wait;
		if (!arst_n) begin
			out_stall     <= 1'b0;
			take_wait     <= 0;
			results_taken <= 0;
		end else begin
			next_wait = (take_wait != 0) ? take_wait - 1 : 0;
			if (out_valid && !out_stall) begin
				check_result(out_item);
				results_taken <= results_taken + 1;
				next_wait = ((results_taken / 8) % 3 == 0) ? 0 : $urandom_range(0, 11);
			end
			take_wait <= next_wait;
			out_stall <= (next_wait != 0) || (hold_left != 0);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("rod_cutting_max_revenue_test: done, errors");
			$finish;
		end
	end

	// Stimulus, reset and end of run
	initial begin : stimulus
		int             sel;
		int             len;
		int             directed;
		price_pattern_t pat;

		// directed: single pieces at both extremes of price
		add_price(0, 1'b1);
		add_price(65535, 1'b1);
		// textbook price list, cutting beats the whole rod
		add_price(1, 1'b0);
		add_price(5, 1'b0);
		add_price(8, 1'b0);
		add_price(9, 1'b0);
		add_price(10, 1'b0);
		add_price(17, 1'b0);
		add_price(17, 1'b0);
		add_price(20, 1'b1);
		// all prices at maximum: unit pieces win
		add_list(3, PAT_PEAK);
		// only the full length has value
		add_price(0, 1'b0);
		add_price(0, 1'b0);
		add_price(0, 1'b0);
		add_price(100, 1'b1);
		// a dear short piece and a worthless long one
		add_price(65535, 1'b0);
		add_price(0, 1'b1);
		directed = price_feed.size();

		// longest rod at peak prices, then an over-long list
		add_list(MAX_LEN, PAT_PEAK);
		add_list(MAX_LEN + 6, PAT_RANDOM);

		// random lists, mostly short to keep the quadratic fill cheap
		while (price_feed.size() < directed + RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 85)
				len = $urandom_range(1, 8);
			else if (sel < 95)
				len = $urandom_range(9, 32);
			else if (sel < 99)
				len = $urandom_range(33, MAX_LEN);
			else
				len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
			sel = $urandom_range(0, 9);
			if (sel < 5)
				pat = PAT_RANDOM;
			else if (sel == 5)
				pat = PAT_PEAK;
			else if (sel == 6)
				pat = PAT_ZERO;
			else if (sel < 9)
				pat = PAT_LOW;
			else
				pat = PAT_RISING;
			add_list(len, pat);
		end

		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the feed to drain and every result to arrive
		do
			@(posedge clk);
		while (price_feed.size() != 0 || in_valid || revenue_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("rod_cutting_max_revenue_test: done, clean");
		else
			$display("rod_cutting_max_revenue_test: done, errors");
		$finish;
	end

endmodule
